// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the distance core; compiled away when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked property, disabled while reset is low
`define FSQD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that holds in reset as well
`define FSQD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FSQD_ASSERT(lbl, clk, rstn, prop, msg)
`define FSQD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/fsqd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqd_pkg
// Constants and helpers for the approximate distance pipeline: float
// constants, leading-zero count and round-to-nearest-even packing.
// ----------------------------------------------------------------------------
package fsqd_pkg;

  localparam logic [31:0] MAGIC_ROOT   = 32'h5f3759df;
  localparam logic [31:0] FP_HALF      = 32'h3f000000;
  localparam logic [31:0] FP_THREE_HLF = 32'h3fc00000;
  localparam logic [31:0] FP_DFLT_NAN  = 32'hffc00000;
  localparam logic [30:0] WHOLE_MAX    = 31'h7fffffff;
  localparam int unsigned DIV_STEPS    = 28;

  // Early-out result of a float operation
  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } fsqd_spec_t;

  // Count leading zeros of a 48-bit word (48 for zero)
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack; ef is the biased exponent, at least 1
  function automatic logic [31:0] round_pack(input logic sign, input logic [10:0] ef,
                                             input logic [23:0] m, input logic g,
                                             input logic st);
    logic        inc;
    logic [24:0] mr;
    logic [10:0] e2;
    logic [31:0] r;
    inc = g & (st | m[0]);
    mr  = {1'b0, m} + {24'b0, inc};
    e2  = ef + {10'b0, mr[24]};
    if (e2 >= 11'd255) begin
      r = {sign, 8'hff, 23'b0};
    end else if (mr[24]) begin
      r = {sign, e2[7:0], 23'b0};
    end else if (mr[23]) begin
      r = {sign, e2[7:0], mr[22:0]};
    end else begin
      r = {sign, 8'b0, mr[22:0]};
    end
    return r;
  endfunction

endpackage

// ===== design/fsqd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqd_mul
// Three-stage single-precision multiplier, round to nearest even, with
// subnormal operands and results. Stages: multiply, count zeros, shift/round.
// ----------------------------------------------------------------------------
module fsqd_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  // stage 1: classify and multiply significands
  logic [7:0]          ea, eb;
  logic [9:0]          eea, eeb;
  logic                a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  fsqd_pkg::fsqd_spec_t spec_d;

  fsqd_pkg::fsqd_spec_t s1_spec_q;
  logic                 s1_sign_q;
  logic signed [10:0]   s1_base_q;
  logic [47:0]          s1_prod_q;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    eea    = (ea == 8'd0) ? 10'd1 : {2'b0, ea};
    eeb    = (eb == 8'd0) ? 10'd1 : {2'b0, eb};
    a_nan  = (ea == 8'hff) && (a_i[22:0] != 23'd0);
    b_nan  = (eb == 8'hff) && (b_i[22:0] != 23'd0);
    a_inf  = (ea == 8'hff) && (a_i[22:0] == 23'd0);
    b_inf  = (eb == 8'hff) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    sgn    = a_i[31] ^ b_i[31];
    spec_d = '{hit: 1'b1, value: 32'd0};
    if (a_nan) begin
      spec_d.value = a_i | 32'h0040_0000;
    end else if (b_nan) begin
      spec_d.value = b_i | 32'h0040_0000;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      spec_d.value = fsqd_pkg::FP_DFLT_NAN;
    end else if (a_inf || b_inf) begin
      spec_d.value = {sgn, 8'hff, 23'b0};
    end else if (a_zero || b_zero) begin
      spec_d.value = {sgn, 31'b0};
    end else begin
      spec_d.hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_spec_q <= spec_d;
      s1_sign_q <= sgn;
      s1_base_q <= $signed({1'b0, eea}) + $signed({1'b0, eeb}) - 11'sd126;
      s1_prod_q <= {(ea != 8'd0), a_i[22:0]} * {(eb != 8'd0), b_i[22:0]};
    end
  end

  // stage 2: pick the normalizing shift, clamped at the subnormal limit
  logic [5:0]         lz;
  logic signed [10:0] tmp, ls_d, ef_d;

  fsqd_pkg::fsqd_spec_t s2_spec_q;
  logic                 s2_sign_q;
  logic signed [10:0]   s2_ls_q, s2_ef_q;
  logic [47:0]          s2_prod_q;

  always_comb begin
    lz  = fsqd_pkg::lzc48(s1_prod_q);
    tmp = s1_base_q - $signed({5'b0, lz});
    if (tmp >= 11'sd1) begin
      ls_d = $signed({5'b0, lz});
      ef_d = tmp;
    end else begin
      ls_d = s1_base_q - 11'sd1;
      ef_d = 11'sd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_spec_q <= s1_spec_q;
      s2_sign_q <= s1_sign_q;
      s2_ls_q   <= ls_d;
      s2_ef_q   <= ef_d;
      s2_prod_q <= s1_prod_q;
    end
  end

  // stage 3: shift, round and pack
  logic [10:0] rs;
  logic [95:0] wide;
  logic [47:0] x;
  logic        xs;
  logic [31:0] res_d;
  logic [31:0] p_q;

  always_comb begin
    rs   = 11'(-s2_ls_q);
    wide = '0;
    xs   = 1'b0;
    if (!s2_ls_q[10]) begin
      x = s2_prod_q << s2_ls_q[5:0];
    end else if (rs >= 11'd48) begin
      x  = '0;
      xs = |s2_prod_q;
    end else begin
      wide = {s2_prod_q, 48'b0} >> rs[5:0];
      x    = wide[95:48];
      xs   = |wide[47:0];
    end
    if (s2_spec_q.hit) begin
      res_d = s2_spec_q.value;
    end else begin
      res_d = fsqd_pkg::round_pack(s2_sign_q, s2_ef_q, x[47:24], x[23], (|x[22:0]) | xs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= res_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== design/fsqd_add.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqd_add
// Three-stage single-precision adder/subtractor, round to nearest even, with
// subnormals. Stages: order and align, add and count zeros, shift and round.
// ----------------------------------------------------------------------------
module fsqd_add (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        sub_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);

  // stage 1: classify, order by magnitude, align the smaller operand
  logic [31:0]          bn, big, lil;
  logic                 a_nan, b_nan, a_inf, b_inf;
  logic [9:0]           eeb, eel, dexp;
  logic [23:0]          sigb, sigl;
  logic [53:0]          awide;
  logic [26:0]          al;
  fsqd_pkg::fsqd_spec_t spec_d;

  fsqd_pkg::fsqd_spec_t s1_spec_q;
  logic                 s1_sign_q, s1_effsub_q;
  logic [9:0]           s1_e_q;
  logic [26:0]          s1_big_q, s1_lil_q;

  always_comb begin
    bn     = {b_i[31] ^ sub_i, b_i[30:0]};
    a_nan  = (a_i[30:23] == 8'hff) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hff) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hff) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hff) && (b_i[22:0] == 23'd0);
    spec_d = '{hit: 1'b1, value: 32'd0};
    if (a_nan) begin
      spec_d.value = a_i | 32'h0040_0000;
    end else if (b_nan) begin
      spec_d.value = b_i | 32'h0040_0000;
    end else if (a_inf && b_inf && (a_i[31] != bn[31])) begin
      spec_d.value = fsqd_pkg::FP_DFLT_NAN;
    end else if (a_inf) begin
      spec_d.value = a_i;
    end else if (b_inf) begin
      spec_d.value = bn;
    end else begin
      spec_d.hit = 1'b0;
    end
    if (bn[30:0] > a_i[30:0]) begin
      big = bn;
      lil = a_i;
    end else begin
      big = a_i;
      lil = bn;
    end
    eeb   = (big[30:23] == 8'd0) ? 10'd1 : {2'b0, big[30:23]};
    eel   = (lil[30:23] == 8'd0) ? 10'd1 : {2'b0, lil[30:23]};
    sigb  = {(big[30:23] != 8'd0), big[22:0]};
    sigl  = {(lil[30:23] != 8'd0), lil[22:0]};
    dexp  = eeb - eel;
    awide = '0;
    if (dexp >= 10'd27) begin
      al = {26'b0, |sigl};
    end else begin
      awide = {sigl, 3'b0, 27'b0} >> dexp[4:0];
      al    = awide[53:27] | {26'b0, |awide[26:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_spec_q   <= spec_d;
      s1_sign_q   <= big[31];
      s1_effsub_q <= big[31] ^ lil[31];
      s1_e_q      <= eeb;
      s1_big_q    <= {sigb, 3'b0};
      s1_lil_q    <= al;
    end
  end

  // stage 2: add or subtract, then choose the normalizing shift
  logic [27:0] sum;
  logic [5:0]  lz, want, ls_d;
  logic [9:0]  lim, e_d;

  fsqd_pkg::fsqd_spec_t s2_spec_q;
  logic                 s2_sign_q, s2_effsub_q, s2_zero_q;
  logic [27:0]          s2_sum_q;
  logic [5:0]           s2_ls_q;
  logic [9:0]           s2_e_q;

  always_comb begin
    if (s1_effsub_q) begin
      sum = {1'b0, s1_big_q} - {1'b0, s1_lil_q};
    end else begin
      sum = {1'b0, s1_big_q} + {1'b0, s1_lil_q};
    end
    lz   = fsqd_pkg::lzc48({sum, 20'b0});
    want = lz - 6'd1;
    lim  = s1_e_q - 10'd1;
    if ({4'b0, want} <= lim) begin
      ls_d = want;
    end else begin
      ls_d = lim[5:0];
    end
    if (sum[27]) begin
      ls_d = 6'd0;
      e_d  = s1_e_q + 10'd1;
    end else begin
      e_d  = s1_e_q - {4'b0, ls_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_spec_q   <= s1_spec_q;
      s2_sign_q   <= s1_sign_q;
      s2_effsub_q <= s1_effsub_q;
      s2_zero_q   <= (sum == 28'd0);
      s2_sum_q    <= sum;
      s2_ls_q     <= ls_d;
      s2_e_q      <= e_d;
    end
  end

  // stage 3: shift, round and pack
  logic [26:0] x;
  logic [31:0] res_d;
  logic [31:0] s_q;

  always_comb begin
    if (s2_sum_q[27]) begin
      x = {s2_sum_q[27:2], s2_sum_q[1] | s2_sum_q[0]};
    end else begin
      x = s2_sum_q[26:0] << s2_ls_q;
    end
    if (s2_spec_q.hit) begin
      res_d = s2_spec_q.value;
    end else if (s2_zero_q) begin
      // exact zero keeps a sign only when both operands carried it
      res_d = {s2_sign_q & ~s2_effsub_q, 31'b0};
    end else begin
      res_d = fsqd_pkg::round_pack(s2_sign_q, {1'b0, s2_e_q}, x[26:3], x[2], x[1] | x[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= res_d;
    end
  end

  assign s_o = s_q;

endmodule

// ===== design/fast_inv_sqrt_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inv_sqrt_distance_core
// Approximate Euclidean distance of two single-precision points by the
// magic-constant inverse square root, one Newton step and a reciprocal.
// ----------------------------------------------------------------------------
// Fully pipelined: one request enters per clock unless the pipe holds; it
// passes 54 internal stages and then the output register. The stages are
// eight float units of three stages each and the reciprocal, which
// retires one quotient bit per stage over 28 stages plus a normalize and a
// round stage. The whole pipe advances together; it holds only while a
// result waits at the output and the consumer is not ready. No state is
// kept between requests.
// ----------------------------------------------------------------------------
module fast_inv_sqrt_distance_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] distance_bits_o,
  output logic [30:0] distance_whole_o,
  output logic        saturated_o
);

  `include "assert_macros.svh"

  localparam int unsigned Steps    = fsqd_pkg::DIV_STEPS;
  localparam int unsigned Latency  = 8 * 3 + 1 + Steps + 1;
  localparam int unsigned Y0Depth  = 12;

  logic en;
  logic out_valid_q;

  // advance the whole pipe unless a result is stuck at the output
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // valid bits travel alongside the data
  logic [Latency-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_valid_i};
    end
  end

  // differences, squares and their sum
  logic [31:0] dx, dy, sx, sy, ssum;

  fsqd_add u_dx (.clk_i, .en_i(en), .sub_i(1'b1), .a_i(second_x_i), .b_i(first_x_i),
                 .s_o(dx));
  fsqd_add u_dy (.clk_i, .en_i(en), .sub_i(1'b1), .a_i(second_y_i), .b_i(first_y_i),
                 .s_o(dy));
  fsqd_mul u_sx (.clk_i, .en_i(en), .a_i(dx), .b_i(dx), .p_o(sx));
  fsqd_mul u_sy (.clk_i, .en_i(en), .a_i(dy), .b_i(dy), .p_o(sy));
  fsqd_add u_ss (.clk_i, .en_i(en), .sub_i(1'b0), .a_i(sx), .b_i(sy), .s_o(ssum));

  // initial guess from the bit pattern, delayed to meet each Newton operand
  logic [31:0] guess;
  logic [31:0] y0_q [Y0Depth];

  assign guess = fsqd_pkg::MAGIC_ROOT - {ssum[31], ssum[31:1]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      y0_q[0] <= guess;
      for (int i = 1; i < Y0Depth; i++) begin
        y0_q[i] <= y0_q[i-1];
      end
    end
  end

  // Newton step: y * (1.5 - (0.5*s)*y*y)
  logic [31:0] half, t1, t2, t3, yn;

  fsqd_mul u_half (.clk_i, .en_i(en), .a_i(fsqd_pkg::FP_HALF), .b_i(ssum), .p_o(half));
  fsqd_mul u_t1   (.clk_i, .en_i(en), .a_i(half), .b_i(y0_q[2]), .p_o(t1));
  fsqd_mul u_t2   (.clk_i, .en_i(en), .a_i(t1), .b_i(y0_q[5]), .p_o(t2));
  fsqd_add u_t3   (.clk_i, .en_i(en), .sub_i(1'b1), .a_i(fsqd_pkg::FP_THREE_HLF),
                   .b_i(t2), .s_o(t3));
  fsqd_mul u_yn   (.clk_i, .en_i(en), .a_i(y0_q[11]), .b_i(t3), .p_o(yn));

  // reciprocal, normalize stage: specials and divisor normalization
  logic [7:0]           ey;
  logic [23:0]          ysig;
  logic [5:0]           ylz;
  fsqd_pkg::fsqd_spec_t dv_spec_d;

  fsqd_pkg::fsqd_spec_t dv_spec_q [Steps+1];
  logic                 dv_sign_q [Steps+1];
  logic signed [10:0]   dv_e_q    [Steps+1];
  logic [23:0]          dv_my_q   [Steps+1];
  logic [25:0]          dv_rem_q  [Steps+1];
  logic [Steps-1:0]     dv_quo_q  [Steps+1];

  always_comb begin
    ey        = yn[30:23];
    ysig      = {(ey != 8'd0), yn[22:0]};
    ylz       = fsqd_pkg::lzc48({ysig, 24'b0});
    dv_spec_d = '{hit: 1'b1, value: 32'd0};
    if ((ey == 8'hff) && (yn[22:0] != 23'd0)) begin
      dv_spec_d.value = yn | 32'h0040_0000;
    end else if (yn[30:0] == 31'd0) begin
      dv_spec_d.value = {yn[31], 8'hff, 23'b0};
    end else if (ey == 8'hff) begin
      dv_spec_d.value = {yn[31], 31'b0};
    end else begin
      dv_spec_d.hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_spec_q[0] <= dv_spec_d;
      dv_sign_q[0] <= yn[31];
      dv_e_q[0]    <= 11'sd253 - $signed({3'b0, ((ey == 8'd0) ? 8'd1 : ey)})
                      + $signed({5'b0, ylz});
      dv_my_q[0]   <= ysig << ylz[4:0];
      dv_rem_q[0]  <= 26'h0800000;
      dv_quo_q[0]  <= '0;
    end
  end

  // reciprocal, one restoring quotient bit per stage
  for (genvar k = 0; k < Steps; k++) begin : g_div
    logic        ge;
    logic [25:0] diff;

    assign ge   = dv_rem_q[k] >= {2'b0, dv_my_q[k]};
    assign diff = ge ? (dv_rem_q[k] - {2'b0, dv_my_q[k]}) : dv_rem_q[k];

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_spec_q[k+1] <= dv_spec_q[k];
        dv_sign_q[k+1] <= dv_sign_q[k];
        dv_e_q[k+1]    <= dv_e_q[k];
        dv_my_q[k+1]   <= dv_my_q[k];
        dv_rem_q[k+1]  <= {diff[24:0], 1'b0};
        dv_quo_q[k+1]  <= {dv_quo_q[k][Steps-2:0], ge};
      end
    end
  end

  // reciprocal, round stage
  logic [Steps-1:0]   qv, qn;
  logic signed [10:0] en_e;
  logic [10:0]        rsh;
  logic [29:0]        qwide;
  logic [27:0]        qs;
  logic               qlost;
  logic [31:0]        rnd_d;
  logic [31:0]        rnd_q;

  always_comb begin
    qv    = dv_quo_q[Steps];
    qn    = qv[Steps-1] ? qv : {qv[Steps-2:0], 1'b0};
    en_e  = dv_e_q[Steps] + $signed({10'b0, qv[Steps-1]});
    rsh   = '0;
    qwide = {qn, 2'b0};
    if (en_e < 11'sd1) begin
      // subnormal quotient: at most two places to the right
      rsh   = 11'(11'sd1 - en_e);
      qwide = {qn, 2'b0} >> rsh[1:0];
      en_e  = 11'sd1;
    end
    qs    = qwide[29:2];
    qlost = |qwide[1:0];
    if (dv_spec_q[Steps].hit) begin
      rnd_d = dv_spec_q[Steps].value;
    end else begin
      rnd_d = fsqd_pkg::round_pack(dv_sign_q[Steps], en_e, qs[27:4], qs[3],
                                   (|qs[2:0]) | qlost | (|dv_rem_q[Steps]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rnd_q <= rnd_d;
    end
  end

  // integer conversion with saturation
  logic [7:0]  de;
  logic [4:0]  ish;
  logic [53:0] iwide;
  logic [30:0] whole_d;
  logic        sat_d;

  always_comb begin
    de      = rnd_q[30:23];
    ish     = 5'(de - 8'd127);
    iwide   = {30'b0, 1'b1, rnd_q[22:0]} << ish;
    whole_d = '0;
    sat_d   = 1'b0;
    if ((de == 8'hff) && (rnd_q[22:0] != 23'd0)) begin
      whole_d = fsqd_pkg::WHOLE_MAX;
      sat_d   = 1'b1;
    end else if (!rnd_q[31] && (de >= 8'd158)) begin
      whole_d = fsqd_pkg::WHOLE_MAX;
      sat_d   = 1'b1;
    end else if (rnd_q[31] && (de >= 8'd127)) begin
      sat_d   = 1'b1;
    end else if (!rnd_q[31] && (de >= 8'd127)) begin
      whole_d = iwide[53:23];
    end
  end

  // output register
  logic [31:0] dist_q;
  logic [30:0] whole_q;
  logic        sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[Latency-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q  <= rnd_q;
      whole_q <= whole_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_bits_o  = dist_q;
  assign distance_whole_o = whole_q;
  assign saturated_o      = sat_q;

  // a NaN distance always reports the clamped top value
  `FSQD_ASSERT(a_nan_sat, clk_i, rst_ni, (out_valid_o && (distance_bits_o[30:23] == 8'hff) && (distance_bits_o[22:0] != 23'd0)) |-> (saturated_o && (distance_whole_o == fsqd_pkg::WHOLE_MAX)), "NaN distance not saturated")
  // a clamped result is either the top value or zero
  `FSQD_ASSERT(a_sat_vals, clk_i, rst_ni, (out_valid_o && saturated_o) |-> ((distance_whole_o == fsqd_pkg::WHOLE_MAX) || (distance_whole_o == 31'd0)), "bad clamped value")
  // a nonzero whole part comes only from a positive distance or a NaN of either sign
  `FSQD_ASSERT(a_whole_sign, clk_i, rst_ni, (out_valid_o && (distance_whole_o != 31'd0)) |-> (!distance_bits_o[31] || (distance_bits_o[30:23] == 8'hff)), "whole part from negative distance")

endmodule
